// ===== hdl/fcse_pkg.sv =====
// ----------------------------------------------------------------------------
// fcse_pkg
// Shared constants and types of the front coding string encoder.
// ----------------------------------------------------------------------------
package fcse_pkg;

	localparam int MAX_LEN    = 4096;
	localparam int MATCH_CAP  = (MAX_LEN < 16383) ? MAX_LEN : 16383;
	localparam int POS_W      = $clog2(MAX_LEN + 1);
	localparam int ADDR_W     = $clog2(MAX_LEN);
	localparam int OFS_W      = 37;
	localparam int BSIZE_W    = 16;
	localparam int BSIZE_RST  = 16;
	localparam int MAX_RES    = 3;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_PREFIX = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_TERM   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		kind_t            byte_kind;
		logic             block_start;
		logic [OFS_W-1:0] byte_offset;
		logic             too_long;
		logic             run_last;
	} result_t;

	// results of one item handed to the output queue
	typedef struct packed {
		logic [1:0]            push_n;
		result_t [MAX_RES-1:0] res;
	} push_t;

endpackage

// ===== hdl/fcse_ifs.sv =====
// ----------------------------------------------------------------------------
// fcse channel interfaces
// Valid/ready channels for input items, results and the block size register.
// ----------------------------------------------------------------------------
interface fcse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_end;

	modport source (output valid, output in_byte, output is_end, input ready);
	modport sink (input valid, input in_byte, input is_end, output ready);
endinterface

interface fcse_out_if;
	logic                      valid;
	logic                      ready;
	logic [7:0]                out_byte;
	logic [1:0]                byte_kind;
	logic                      block_start;
	logic [fcse_pkg::OFS_W-1:0] byte_offset;
	logic                      too_long;
	logic                      run_last;

	modport source (output valid, output out_byte, output byte_kind, output block_start,
		output byte_offset, output too_long, output run_last, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input block_start,
		input byte_offset, input too_long, input run_last, output ready);
endinterface

interface fcse_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [fcse_pkg::BSIZE_W-1:0] block_size;

	modport source (output valid, output block_size, input ready);
	modport sink (input valid, input block_size, output ready);
endinterface

// ===== hdl/fcse_core.sv =====
// ----------------------------------------------------------------------------
// fcse_core
// Input stage, previous string store, match state and result building.
// ----------------------------------------------------------------------------
module fcse_core (
	input  logic            clk,
	input  logic            arst_n,
	fcse_in_if.sink         items,
	fcse_cfg_if.sink        cfg,
	input  logic            fifo_room,
	output fcse_pkg::push_t push
);

	logic                           valid_s1;
	logic [7:0]                     byte_s1;
	logic                           end_s1;
	logic [7:0]                     prev_rd_s1;

	logic [fcse_pkg::POS_W-1:0]     char_pos_q;
	logic [fcse_pkg::POS_W-1:0]     prev_len_q;
	logic                           matching_q;
	logic [fcse_pkg::BSIZE_W-1:0]   sib_q;
	logic [fcse_pkg::OFS_W-1:0]     offset_q;
	logic                           too_long_q;
	logic [fcse_pkg::BSIZE_W-1:0]   block_size_q;

	logic [7:0] mem [fcse_pkg::MAX_LEN];

	logic                           in_fire;
	logic                           fire_s1;
	logic                           first;
	logic                           in_range;
	logic                           cont;
	logic                           need_vb;
	logic                           has_final;
	logic                           tl_eff;
	logic                           short_len;
	logic [13:0]                    p14;
	logic [1:0]                     vb_n;
	logic [1:0]                     cnt;
	logic [fcse_pkg::POS_W-1:0]     pos_nxt;
	logic [fcse_pkg::BSIZE_W:0]     sib_inc;
	logic [fcse_pkg::BSIZE_W-1:0]   lim;
	logic                           wr_en;
	fcse_pkg::result_t              vb0, vb1, fin;
	fcse_pkg::result_t [fcse_pkg::MAX_RES-1:0] res;

	assign items.ready = !valid_s1 || fifo_room;
	assign in_fire     = items.valid && items.ready;
	assign fire_s1     = valid_s1 && fifo_room;
	assign cfg.ready   = 1'b1;

	assign first    = (sib_q == '0);
	assign in_range = (char_pos_q < fcse_pkg::POS_W'(fcse_pkg::MAX_LEN));
	assign cont     = !first && matching_q && (char_pos_q < prev_len_q)
		&& (char_pos_q < fcse_pkg::POS_W'(fcse_pkg::MATCH_CAP)) && (prev_rd_s1 == byte_s1);
	assign need_vb   = !first && matching_q && (end_s1 || !cont);
	assign has_final = end_s1 || !cont;
	assign tl_eff    = too_long_q || (!end_s1 && !in_range);
	assign p14       = 14'(char_pos_q);
	assign short_len = (p14 < 14'd128);
	assign vb_n      = need_vb ? (short_len ? 2'd1 : 2'd2) : 2'd0;
	assign cnt       = vb_n + {1'b0, has_final};
	assign wr_en     = fire_s1 && !end_s1 && in_range;

	always_comb begin
		vb0.out_byte    = {short_len, p14[6:0]};
		vb0.byte_kind   = fcse_pkg::KIND_PREFIX;
		vb0.block_start = 1'b0;
		vb0.too_long    = tl_eff;
		vb0.byte_offset = offset_q;
		vb0.run_last    = 1'b0;

		vb1             = vb0;
		vb1.out_byte    = {1'b1, p14[13:7]};

		fin.out_byte    = end_s1 ? 8'd0 : byte_s1;
		fin.byte_kind   = end_s1 ? fcse_pkg::KIND_TERM : fcse_pkg::KIND_CHAR;
		fin.block_start = first && (char_pos_q == '0);
		fin.too_long    = tl_eff;
		fin.byte_offset = offset_q;
		fin.run_last    = 1'b0;

		res[0] = (vb_n != 2'd0) ? vb0 : fin;
		res[1] = (vb_n == 2'd2) ? vb1 : fin;
		res[2] = fin;
		for (int i = 0; i < fcse_pkg::MAX_RES; i++) begin
			res[i].byte_offset = offset_q + fcse_pkg::OFS_W'(i);
			res[i].run_last    = (2'(i) == cnt - 2'd1);
		end

		push.push_n = fire_s1 ? cnt : 2'd0;
		push.res    = res;
	end

	// position of the item that enters next, also the store read address
	always_comb begin
		pos_nxt = char_pos_q;
		if (fire_s1) begin
			if (end_s1) begin
				pos_nxt = '0;
			end else if (in_range) begin
				pos_nxt = char_pos_q + 1'b1;
			end
		end
	end

	assign sib_inc = {1'b0, sib_q} + 1'b1;
	assign lim     = (block_size_q == '0) ? fcse_pkg::BSIZE_W'(1) : block_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			char_pos_q   <= '0;
			prev_len_q   <= '0;
			matching_q   <= 1'b1;
			sib_q        <= '0;
			offset_q     <= '0;
			too_long_q   <= 1'b0;
			block_size_q <= fcse_pkg::BSIZE_W'(fcse_pkg::BSIZE_RST);
		end else begin
			if (cfg.valid) begin
				block_size_q <= cfg.block_size;
			end
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (fire_s1) begin
				offset_q   <= offset_q + fcse_pkg::OFS_W'(cnt);
				char_pos_q <= pos_nxt;
				if (end_s1) begin
					prev_len_q <= char_pos_q;
					matching_q <= 1'b1;
					too_long_q <= 1'b0;
					if (sib_inc >= {1'b0, lim}) begin
						sib_q <= '0;
					end else begin
						sib_q <= sib_inc[fcse_pkg::BSIZE_W-1:0];
					end
				end else begin
					too_long_q <= tl_eff;
					if (need_vb) begin
						matching_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= items.in_byte;
			end_s1  <= items.is_end;
		end
	end

	// store write of the current byte, read at the incoming item's position
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[char_pos_q[fcse_pkg::ADDR_W-1:0]] <= byte_s1;
		end
		if (in_fire) begin
			prev_rd_s1 <= mem[pos_nxt[fcse_pkg::ADDR_W-1:0]];
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		char_pos_q <= fcse_pkg::POS_W'(fcse_pkg::MAX_LEN))
		else $error("char position beyond limit");

	a_first_matching: assert property (@(posedge clk) disable iff (!arst_n)
		!matching_q |-> (sib_q != '0))
		else $error("mismatch state inside a block's first string");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && end_s1) |=> (char_pos_q == '0) && matching_q && !too_long_q)
		else $error("string end did not clear string state");

endmodule

// ===== hdl/fcse_res_fifo.sv =====
// ----------------------------------------------------------------------------
// fcse_res_fifo
// Result queue: takes up to three results at once, hands out one per word.
// ----------------------------------------------------------------------------
module fcse_res_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  fcse_pkg::push_t push,
	output logic            room,
	fcse_out_if.source      results
);

	fcse_pkg::result_t            ent_q [fcse_pkg::FIFO_DEPTH];
	logic [fcse_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [fcse_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [fcse_pkg::FIFO_CW-1:0] count_q;
	logic                         pop;
	fcse_pkg::result_t            head;

	assign room = (count_q <= fcse_pkg::FIFO_CW'(fcse_pkg::FIFO_DEPTH - fcse_pkg::MAX_RES));
	assign pop  = results.valid && results.ready;
	assign head = ent_q[rd_ptr_q];

	assign results.valid       = (count_q != '0);
	assign results.out_byte    = head.out_byte;
	assign results.byte_kind   = head.byte_kind;
	assign results.block_start = head.block_start;
	assign results.byte_offset = head.byte_offset;
	assign results.too_long    = head.too_long;
	assign results.run_last    = head.run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + fcse_pkg::FIFO_AW'(push.push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + fcse_pkg::FIFO_CW'(push.push_n) - fcse_pkg::FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < fcse_pkg::MAX_RES; i++) begin
			if (2'(i) < push.push_n) begin
				ent_q[wr_ptr_q + fcse_pkg::FIFO_AW'(i)] <= push.res[i];
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fcse_pkg::FIFO_CW'(fcse_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.push_n != 2'd0) |-> room)
		else $error("results pushed without room");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.push_n == 2'd0) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count wrong after pop");

endmodule

// ===== hdl/front_coding_string_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// front_coding_string_encoder_unit
// Plain front coder with VByte prefix lengths over a byte-per-word stream.
// ----------------------------------------------------------------------------
// items: one character per word, or an end marker (is_end) that closes the
// current string. results: encoded bytes with kind, block start, offset,
// overlong flag and a mark on the last byte caused by each input word.
// cfg: block_size write, always ready; the user must write it only while the
// unit is idle, which the unit does not enforce. An input word is registered
// with the stored previous string byte read at its position from a 4096 x 8
// store with one write and one read port; the two are compared, and the
// word's zero to three result bytes are written into an 8-entry result
// queue once it has room, and the first of them is offered from there.
// Throughput is one input word per cycle while the queue has room for three
// results; bursts of two or three bytes at a mismatch or string end drain at
// one result per cycle while taken, so a long run of bursts sets the rate.
// A stalled receiver fills the queue and then holds items.ready low.
// Reset clears all string state, counters and the queue; block_size goes to
// 16. The previous string store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module front_coding_string_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	fcse_in_if.sink     items,
	fcse_out_if.source  results,
	fcse_cfg_if.sink    cfg
);

	fcse_pkg::push_t push;
	logic            room;

	fcse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg       (cfg),
		.fifo_room (room),
		.push      (push)
	);

	fcse_res_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.results (results)
	);

endmodule
